/* sv/itm_stimulus_packet_filter_macros.svh */
// Assertion macros for the stimulus packet filter checker.
// Depends on nothing; the including module must have clk and rst_n in scope.
`ifndef ITM_STIMULUS_PACKET_FILTER_MACROS_SVH
`define ITM_STIMULUS_PACKET_FILTER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ISPF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define ISPF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/ispf_pkg.sv */
// Shared types and constants of the stimulus packet filter.
// Used by the controller, the datapath and the top level; depends on nothing.
package ispf_pkg;

    // Default packet buffer depth in bytes
    localparam int unsigned PACKET_BYTES_DEFAULT = 64;

    // Configuration register indexes and address decode
    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic REG_CHANNEL_MASK = 1'b0;

    // Stream payload layout
    localparam int unsigned S_TDATA_W = 16;
    localparam int unsigned M_TDATA_W = 8;

    // Header fields
    localparam int unsigned HDR_BAD_BIT = 2;
    localparam logic [1:0] SIZE_NONE = 2'd0;
    localparam logic [1:0] SIZE_1B   = 2'd1;
    localparam logic [1:0] SIZE_2B   = 2'd2;
    localparam logic [1:0] SIZE_4B   = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FLUSH_RD,
        ST_FLUSH_LD
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;     // input item taken this cycle
        logic rd_start;   // restart read index for a flush
        logic rd_issue;   // read packet store at read index
        logic load_out;   // move read data into the output register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic flush_req;  // current input would flush a full buffer to the link
        logic out_free;   // output register can take a byte this cycle
        logic rd_last;    // read index points at the final stored byte
    } dp_status_t;

endpackage

/* sv/ispf_ctrl.sv */
// Controller state machine of the stimulus packet filter.
// Depends on ispf_pkg for the state and command/status types.
module ispf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  ispf_pkg::dp_status_t status,
    output ispf_pkg::dp_cmd_t    cmd
);

    ispf_pkg::ctrl_state_t state_reg;
    ispf_pkg::ctrl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ispf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ispf_pkg::ST_IDLE:
            begin
                if (s_tvalid && status.flush_req)
                begin
                    state_next = ispf_pkg::ST_FLUSH_RD;
                end
            end
            ispf_pkg::ST_FLUSH_RD:
            begin
                state_next = ispf_pkg::ST_FLUSH_LD;
            end
            ispf_pkg::ST_FLUSH_LD:
            begin
                if (status.out_free)
                begin
                    state_next = status.rd_last ? ispf_pkg::ST_IDLE : ispf_pkg::ST_FLUSH_RD;
                end
            end
            default:
            begin
                state_next = ispf_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs: take items only when idle, stream the store out during a flush
    always_comb
    begin
        s_tready     = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            ispf_pkg::ST_IDLE:
            begin
                s_tready     = 1'b1;
                cmd.accept   = s_tvalid;
                cmd.rd_start = s_tvalid && status.flush_req;
            end
            ispf_pkg::ST_FLUSH_RD:
            begin
                cmd.rd_issue = 1'b1;
            end
            ispf_pkg::ST_FLUSH_LD:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

/* sv/ispf_datapath.sv */
// Datapath of the stimulus packet filter: header decode, packet store,
// read-out index and output register. Depends on ispf_pkg.
module ispf_datapath #(
    parameter int unsigned PACKET_BYTES = ispf_pkg::PACKET_BYTES_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ispf_pkg::dp_cmd_t    cmd,
    output ispf_pkg::dp_status_t status,
    input  logic [7:0]           data_byte,
    input  logic                 link_ready,
    input  logic [31:0]          channel_mask,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [7:0]           out_byte,
    output logic                 last_of_packet
);

    localparam int unsigned AW = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(PACKET_BYTES - 1);

    logic [7:0]    store_mem [PACKET_BYTES];
    logic [7:0]    rd_data_reg;

    logic [2:0]    payload_left_reg;
    logic [2:0]    payload_left_next;
    logic          fwd_en_reg;
    logic          fwd_en_next;
    logic [AW-1:0] fill_count_reg;
    logic [AW-1:0] fill_count_next;
    logic [AW-1:0] rd_idx_reg;
    logic [AW-1:0] rd_idx_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [7:0]    out_byte_reg;
    logic          out_last_reg;

    logic          hdr_ok;
    logic          store_we;
    logic          fill_full;

    assign hdr_ok    = !data_byte[ispf_pkg::HDR_BAD_BIT] && (data_byte[1:0] != ispf_pkg::SIZE_NONE);
    assign fill_full = (fill_count_reg == LAST_IDX);
    assign store_we  = cmd.accept && (payload_left_reg != 3'd0) && fwd_en_reg;

    // Status towards the controller
    always_comb
    begin
        status.flush_req = (payload_left_reg != 3'd0) && fwd_en_reg && fill_full && link_ready;
        status.out_free  = !out_valid_reg || m_tready;
        status.rd_last   = (rd_idx_reg == LAST_IDX);
    end

    // Decode headers, count payload and fill level
    always_comb
    begin
        payload_left_next = payload_left_reg;
        fwd_en_next       = fwd_en_reg;
        fill_count_next   = fill_count_reg;
        if (cmd.accept)
        begin
            if (payload_left_reg == 3'd0)
            begin
                if (hdr_ok)
                begin
                    fwd_en_next = channel_mask[data_byte[7:3]];
                    unique case (data_byte[1:0])
                        ispf_pkg::SIZE_1B: payload_left_next = 3'd1;
                        ispf_pkg::SIZE_2B: payload_left_next = 3'd2;
                        ispf_pkg::SIZE_4B: payload_left_next = 3'd4;
                        default:           payload_left_next = 3'd0;
                    endcase
                end
                else
                begin
                    fwd_en_next     = 1'b0;
                    fill_count_next = '0;
                end
            end
            else
            begin
                payload_left_next = payload_left_reg - 3'd1;
                if (fwd_en_reg)
                begin
                    fill_count_next = fill_full ? '0 : fill_count_reg + AW'(1);
                end
            end
        end
    end

    // Advance the read index through the store during a flush
    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        if (cmd.rd_start)
        begin
            rd_idx_next = '0;
        end
        else if (cmd.load_out && !status.rd_last)
        begin
            rd_idx_next = rd_idx_reg + AW'(1);
        end
    end

    // Hold a byte until the sink takes it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            payload_left_reg <= 3'd0;
            fwd_en_reg       <= 1'b0;
            fill_count_reg   <= '0;
            rd_idx_reg       <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            payload_left_reg <= payload_left_next;
            fwd_en_reg       <= fwd_en_next;
            fill_count_reg   <= fill_count_next;
            rd_idx_reg       <= rd_idx_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Packet store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[fill_count_reg] <= data_byte;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= store_mem[rd_idx_reg];
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_byte_reg <= rd_data_reg;
            out_last_reg <= status.rd_last;
        end
    end

    assign m_tvalid       = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign last_of_packet = out_last_reg;

endmodule

/* sv/itm_stimulus_packet_filter.sv */
// Top level of the stimulus packet filter: configuration register, controller
// and datapath. Depends on ispf_pkg, ispf_ctrl and ispf_datapath.

// The block takes one trace byte per input item and accepts an item every cycle
// while no flush is running. When PACKET_BYTES forwarded payload bytes have been
// collected and the item that completes them has link_ready set, input stops for
// the flush: each stored byte is first read from the packet store through its
// single registered read port and then loaded into the output register, so a flush
// holds the input until every stored byte has passed both steps and while the sink
// stalls. Items are taken again in the cycle the final byte enters the output
// register, even while it still waits there. Write channel_mask only while idle.
module itm_stimulus_packet_filter #(
    parameter int unsigned PACKET_BYTES = ispf_pkg::PACKET_BYTES_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ispf_pkg::S_TDATA_W-1:0]    s_tdata,   // [7:0] data_byte, [8] link_ready
    // Output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ispf_pkg::M_TDATA_W-1:0]    m_tdata,   // [7:0] out_byte
    output logic                              m_tlast,   // last_of_packet
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ispf_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    ispf_pkg::dp_cmd_t    cmd;
    ispf_pkg::dp_status_t status;

    logic [31:0] channel_mask_reg;
    logic [31:0] channel_mask_next;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // Register write decode
    always_comb
    begin
        channel_mask_next = channel_mask_reg;
        if (cfg_write && (paddr[2] == ispf_pkg::REG_CHANNEL_MASK))
        begin
            channel_mask_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_mask_reg <= 32'd0;
        end
        else
        begin
            channel_mask_reg <= channel_mask_next;
        end
    end

    // Register read-back
    assign prdata = (paddr[2] == ispf_pkg::REG_CHANNEL_MASK) ? channel_mask_reg : 32'd0;

    ispf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ispf_datapath #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .data_byte      (s_tdata[7:0]),
        .link_ready     (s_tdata[8]),
        .channel_mask   (channel_mask_reg),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .out_byte       (m_tdata),
        .last_of_packet (m_tlast)
    );

endmodule

/* sv/ispf_checker.sv */
// Port-level checker of the stimulus packet filter, bound to the top level.
// Depends on itm_stimulus_packet_filter_macros.svh for the assertion macros.
`include "itm_stimulus_packet_filter_macros.svh"

module ispf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // A stalled output item holds its payload
    `ISPF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output item changed while stalled")

    // No input is taken while a packet is only partly sent
    `ISPF_ASSERT_IMPL(a_no_accept_mid_packet, m_tvalid && !m_tlast, !s_tready, "input ready in the middle of a flush")

    // After a non-final byte leaves, the next byte follows or the flush is still running
    `ISPF_ASSERT_NEXT(a_flush_continues, m_tvalid && m_tready && !m_tlast, m_tvalid || !s_tready, "input ready before the final byte of a flush")

endmodule

bind itm_stimulus_packet_filter ispf_checker u_checker (.*);

/* tb/itm_stimulus_packet_filter_tb.sv */
// Self-checking bench for the stimulus packet filter: trace bytes go in as stream items,
// flushed packets are checked against a local model. Depends on ispf_pkg and the RTL top.
module itm_stimulus_packet_filter_tb;

    localparam int FLUSH_BYTES = ispf_pkg::PACKET_BYTES_DEFAULT;
    localparam int RUN_LIMIT   = 100000;
    localparam int SETTLE_CYC  = 2 * FLUSH_BYTES + 8;

    typedef struct {
        logic [7:0] value;
        logic       link;
    } trace_item_t;

    typedef struct {
        logic [7:0] value;
        logic       is_last;
    } flushed_byte_t;

    logic                            clk      = 1'b0;
    logic                            rst_n    = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [ispf_pkg::S_TDATA_W-1:0]  s_tdata  = '0;  // [7:0] data_byte, [8] link_ready
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [ispf_pkg::M_TDATA_W-1:0]  m_tdata;        // [7:0] out_byte
    logic                            m_tlast;
    logic                            psel     = 1'b0;
    logic                            penable  = 1'b0;
    logic                            pwrite   = 1'b0;
    logic [ispf_pkg::CFG_ADDR_W-1:0] paddr    = '0;
    logic [31:0]                     pwdata   = '0;
    logic [31:0]                     prdata;
    logic                            pready;

    itm_stimulus_packet_filter u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Model state of the filter
    logic [31:0] chan_mask;
    logic [2:0]  pend_left;
    logic        port_on;
    int          fill_cnt;
    logic [7:0]  pkt_store [FLUSH_BYTES];

    trace_item_t   trace_q[$];
    flushed_byte_t flush_q[$];

    int items_queued  = 0;
    int items_taken   = 0;
    int bytes_checked = 0;
    int mask_writes   = 0;
    int err_cnt       = 0;
    int cycle_cnt     = 0;
    int burst_left    = 1;
    int idle_left     = 0;
    int stall_mode    = 0;
    int mode_left     = 0;
    logic in_fire     = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic log_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        err_cnt++;
    endtask

    // Advance the filter model by one trace byte, queueing any flushed packet
    task automatic filter_predict(input logic [7:0] tb_byte, input logic link);
        int i;
        if (pend_left == 3'd0)
        begin
            if (!tb_byte[ispf_pkg::HDR_BAD_BIT] && tb_byte[1:0] != ispf_pkg::SIZE_NONE)
            begin
                case (tb_byte[1:0])
                    ispf_pkg::SIZE_1B: pend_left = 3'd1;
                    ispf_pkg::SIZE_2B: pend_left = 3'd2;
                    default:           pend_left = 3'd4;
                endcase
                port_on = chan_mask[tb_byte[7:3]];
            end
            else
            begin
                port_on  = 1'b0;
                fill_cnt = 0;
            end
        end
        else
        begin
            if (port_on)
            begin
                pkt_store[fill_cnt] = tb_byte;
                fill_cnt++;
                if (fill_cnt >= FLUSH_BYTES)
                begin
                    if (link)
                        for (i = 0; i < FLUSH_BYTES; i++)
                            flush_q.push_back('{pkt_store[i], i == FLUSH_BYTES - 1});
                    fill_cnt = 0;
                end
            end
            pend_left = pend_left - 3'd1;
        end
    endtask

    // Track every handshake: predict on input items, check output items
    always @(posedge clk)
    begin
        flushed_byte_t exp_b;
        in_fire <= rst_n && s_tvalid && s_tready;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                filter_predict(s_tdata[7:0], s_tdata[8]);
                items_taken++;
            end
            if (m_tvalid && m_tready)
            begin
                if (flush_q.size() == 0)
                    log_mismatch($sformatf("unexpected output byte %02h", m_tdata));
                else
                begin
                    exp_b = flush_q.pop_front();
                    if (m_tdata !== exp_b.value)
                        log_mismatch($sformatf("out_byte %02h, expected %02h",
                                               m_tdata, exp_b.value));
                    if (m_tlast !== exp_b.is_last)
                        log_mismatch($sformatf("last_of_packet %0b, expected %0b",
                                               m_tlast, exp_b.is_last));
                    bytes_checked++;
                end
            end
        end
    end

    // Drop the run if it hangs
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == RUN_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_cnt);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Send trace bytes in bursts separated by idle gaps
    always @(negedge clk)
    begin
        trace_item_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else if (!s_tvalid || in_fire)
        begin
            if (idle_left > 0)
            begin
                idle_left--;
                s_tvalid <= 1'b0;
            end
            else if (trace_q.size() > 0)
            begin
                nxt = trace_q.pop_front();
                s_tdata  <= {7'b0, nxt.link, nxt.value};
                s_tvalid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 48);
                    idle_left  = $urandom_range(0, 5);
                end
                else
                    burst_left--;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Stall the output: always ready, coin toss, or ready only one cycle in four
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(20, 120);
            end
            else
                mode_left--;
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= (cycle_cnt % 4 == 3);
            endcase
        end
    end

    task automatic push_trace(input logic [7:0] value, input logic link);
        trace_q.push_back('{value, link});
        items_queued++;
    endtask

    // Write the channel mask, then read it back
    task automatic write_mask(input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ispf_pkg::CFG_ADDR_W'(4 * ispf_pkg::REG_CHANNEL_MASK);
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        chan_mask = value;
        mask_writes++;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== value)
            log_mismatch($sformatf("channel_mask reads %08h, expected %08h", prdata, value));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Hold until every queued item is taken and every flushed byte has arrived
    task automatic wait_quiet();
        while (items_taken != items_queued || flush_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    // Empty the buffer with a malformed header, then fill it with four-byte packets
    task automatic queue_full_buffer(input logic link);
        int p;
        int k;
        push_trace(8'h04, link);
        for (p = 0; p < FLUSH_BYTES / 4; p++)
        begin
            push_trace({5'($urandom_range(0, 31)), 1'b0, ispf_pkg::SIZE_4B}, link);
            for (k = 0; k < 4; k++)
                push_trace(8'($urandom), link);
        end
    endtask

    // Mostly well-formed packets with random content, some malformed headers
    task automatic queue_random_traffic(input int n_items, input int link_pct);
        int added;
        int k;
        int n_pay;
        logic [1:0] sz;
        logic [7:0] hdr;
        added = 0;
        while (added < n_items)
        begin
            if ($urandom_range(0, 99) < 88)
            begin
                sz  = 2'($urandom_range(1, 3));
                hdr = {5'($urandom_range(0, 31)), 1'b0, sz};
                push_trace(hdr, $urandom_range(0, 99) < link_pct);
                n_pay = (sz == ispf_pkg::SIZE_1B) ? 1 : (sz == ispf_pkg::SIZE_2B) ? 2 : 4;
                for (k = 0; k < n_pay; k++)
                    push_trace(8'($urandom), $urandom_range(0, 99) < link_pct);
                added += n_pay + 1;
            end
            else
            begin
                hdr = 8'($urandom);
                if ($urandom_range(0, 1))
                    hdr[ispf_pkg::HDR_BAD_BIT] = 1'b1;
                else
                    hdr[1:0] = ispf_pkg::SIZE_NONE;
                push_trace(hdr, $urandom_range(0, 1));
                added++;
            end
        end
    endtask

    initial
    begin
        chan_mask = '0;
        pend_left = '0;
        port_on   = 1'b0;
        fill_cnt  = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // All ports masked: headers parse, nothing is kept
        write_mask(32'h0000_0000);
        push_trace(8'h00, 1'b1);
        push_trace(8'h79, 1'b0);
        push_trace(8'hE7, 1'b1);
        wait_quiet();

        // Lowest and highest port enabled: size codes, extreme bytes, bad headers
        write_mask(32'h8000_0001);
        push_trace(8'h01, 1'b0);
        push_trace(8'h00, 1'b1);
        push_trace(8'hFB, 1'b1);
        push_trace(8'hFF, 1'b0);
        push_trace(8'h80, 1'b1);
        push_trace(8'h7F, 1'b0);
        push_trace(8'h01, 1'b1);
        push_trace(8'h0A, 1'b0);
        push_trace(8'h55, 1'b1);
        push_trace(8'hAA, 1'b0);
        push_trace(8'h04, 1'b1);
        push_trace(8'hFF, 1'b0);
        push_trace(8'hF8, 1'b1);
        push_trace(8'h02, 1'b0);
        push_trace(8'hC3, 1'b1);
        push_trace(8'h3C, 1'b0);
        // Disabled port, left half way through its payload
        push_trace(8'h0B, 1'b1);
        push_trace(8'h11, 1'b0);
        push_trace(8'h22, 1'b1);
        wait_quiet();

        // Enable everything mid-packet; the pending payload stays dropped.
        // Then fill the buffer with the link down so the flush is discarded.
        write_mask(32'hFFFF_FFFF);
        push_trace(8'h33, 1'b1);
        push_trace(8'h44, 1'b1);
        queue_full_buffer(1'b0);
        wait_quiet();

        // Fill the buffer again with the link up so a whole packet is flushed
        queue_full_buffer(1'b1);
        wait_quiet();

        // Random traffic under a random mask
        write_mask(32'($urandom));
        queue_random_traffic(45, 90);
        wait_quiet();

        $display("Sent %0d trace bytes under %0d mask settings; checked %0d flushed bytes",
                 items_taken, mask_writes, bytes_checked);
        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
